>>> sv/iira_pkg.sv
`timescale 1ns / 1ps

package iira_pkg;

   localparam int WORD_W  = 32;
   localparam int OP_W    = 3;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [OP_W-1:0]          op_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [COUNT_W-1:0]       count_type;
   typedef logic [STAT_W-1:0]        status_type;

   localparam op_type OP_PUSH_BACK = 3'd0;
   localparam op_type OP_POP_BACK  = 3'd1;
   localparam op_type OP_INSERT_AT = 3'd2;
   localparam op_type OP_REMOVE_AT = 3'd3;
   localparam op_type OP_SET_AT    = 3'd4;
   localparam op_type OP_GET_AT    = 3'd5;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_INDEX = 2'd2;
   localparam status_type STATUS_EMPTY = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LOWER,
      CELL_FROM_UPPER
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

endpackage

>>> sv/iira_if.sv
`timescale 1ns / 1ps

interface iira_req_if;
   import iira_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   pos_type  position;
   word_type data_word;

   modport source (output valid, output operation, output position, output data_word,
                   input ready);
   modport sink   (input valid, input operation, input position, input data_word,
                   output ready);
endinterface

interface iira_rsp_if;
   import iira_pkg::*;

   logic       valid;
   logic       ready;
   word_type   read_value;
   word_type   front_value;
   word_type   back_value;
   count_type  count;
   logic       is_empty;
   status_type status;

   modport source (output valid, output read_value, output front_value, output back_value,
                   output count, output is_empty, output status, input ready);
   modport sink   (input valid, input read_value, input front_value, input back_value,
                   input count, input is_empty, input status, output ready);
endinterface

>>> sv/iira_cell.sv
`timescale 1ns / 1ps

module iira_cell (
   input  logic                  clock,
   input  iira_pkg::cell_cmd_type cmd,
   input  iira_pkg::word_type    load_word,
   input  iira_pkg::word_type    lower_word,
   input  iira_pkg::word_type    upper_word,
   output iira_pkg::word_type    word
);
   import iira_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      case (cmd)
         CELL_LOAD:       word_in = load_word;
         CELL_FROM_LOWER: word_in = lower_word;
         CELL_FROM_UPPER: word_in = upper_word;
         default:         word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> sv/indexed_insert_remove_array_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields
// req_chan  in   operation, position, data_word
// rsp_chan  out  read_value, front_value, back_value, count, is_empty, status
//
// For each transaction the cell row shifts or loads in the accept cycle, then in
// the finish step the single shared read mux fetches the new last entry.
// A get reads its entry through the same mux in the accept cycle.
// Synchronous reset clears the entry count and handshake state; cells hold no reset.
// A stalled result holds in the output register; the next request is still
// accepted and waits in the finish step until the output register frees.

module indexed_insert_remove_array_unit #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   iira_req_if.sink   req_chan,
   iira_rsp_if.source rsp_chan
);
   import iira_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type state_ff;
   state_type state_in;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   word_type   get_value_ff;
   word_type   get_value_in;
   status_type status_ff;
   status_type status_in;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   word_type   rsp_read_ff;
   word_type   rsp_front_ff;
   word_type   rsp_back_ff;
   count_type  rsp_count_ff;
   logic       rsp_empty_ff;
   status_type rsp_status_ff;

   logic accept;
   logic rd_sel_back;
   logic rsp_load;

   cell_cmd_type cmds [DEPTH];
   word_type     words [DEPTH];

   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] clamp_x;
   logic             is_zero;
   logic             is_full;
   logic [IDX_W-1:0] rd_addr;
   word_type         rd_word;

   assign cnt_x   = CMP_W'(count_ff);
   assign pos_x   = CMP_W'(req_chan.position);
   assign is_zero = (count_ff == '0);
   assign is_full = (cnt_x >= CMP_W'(DEPTH));
   assign clamp_x = (pos_x >= cnt_x) ? (cnt_x - 1'b1) : pos_x;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_FINISH;
         ST_FINISH: if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rd_sel_back    = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_FINISH: begin
            rd_sel_back = 1'b1;
            rsp_load    = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   assign accept = req_chan.valid && req_chan.ready;

   // decode operation into status, count and per-cell commands
   always_comb begin
      status_in = STATUS_OK;
      count_in  = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cmds[i] = CELL_HOLD;
      end
      if (accept) begin
         unique case (req_chan.operation)
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMP_W'(i) == cnt_x) cmds[i] = CELL_LOAD;
                  end
               end
            end
            OP_POP_BACK: begin
               if (is_zero) status_in = STATUS_EMPTY;
               else         count_in  = count_ff - 1'b1;
            end
            OP_INSERT_AT: begin
               if (pos_x > cnt_x) begin
                  status_in = STATUS_INDEX;
               end else if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMP_W'(i) == pos_x) begin
                        cmds[i] = CELL_LOAD;
                     end else if (CMP_W'(i) > pos_x && CMP_W'(i) <= cnt_x) begin
                        cmds[i] = CELL_FROM_LOWER;
                     end
                  end
               end
            end
            OP_REMOVE_AT: begin
               if (is_zero) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMP_W'(i) >= clamp_x && CMP_W'(i) + 1'b1 < cnt_x) begin
                        cmds[i] = CELL_FROM_UPPER;
                     end
                  end
               end
            end
            OP_SET_AT: begin
               if (is_zero) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMP_W'(i) == clamp_x) cmds[i] = CELL_LOAD;
                  end
               end
            end
            OP_GET_AT: begin
               if (is_zero) status_in = STATUS_EMPTY;
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // cell row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      word_type lower_word;
      word_type upper_word;

      if (g == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = words[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign upper_word = '0;
      end else begin : g_upper
         assign upper_word = words[g+1];
      end

      iira_cell u_cell (
         .clock      (clock),
         .cmd        (cmds[g]),
         .load_word  (req_chan.data_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (words[g])
      );
   end

   // shared read mux: get entry at accept, last entry in the finish step
   assign rd_addr = rd_sel_back ? IDX_W'(count_ff - 1'b1) : IDX_W'(clamp_x);
   assign rd_word = words[rd_addr];

   assign get_value_in = (accept && req_chan.operation == OP_GET_AT && !is_zero)
                         ? rd_word : '0;

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         get_value_ff <= get_value_in;
         status_ff    <= status_in;
      end
      if (rsp_load) begin
         rsp_read_ff   <= get_value_ff;
         rsp_front_ff  <= is_zero ? '0 : words[0];
         rsp_back_ff   <= is_zero ? '0 : rd_word;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_empty_ff  <= is_zero;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.back_value  = rsp_back_ff;
   assign rsp_chan.count       = rsp_count_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.status      = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above capacity");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1
                  || count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");

   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_empty |->
         rsp_chan.front_value == '0 && rsp_chan.back_value == '0
         && rsp_chan.read_value == '0)
      else $error("empty result carries nonzero entry");

   a_no_finish_without_accept : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !accept |=> state_ff == ST_IDLE)
      else $error("finish step without a transaction");

endmodule
